FILE: rtl/ring_finger_table_router_unit_assert.svh
// assertion macros shared by the ring finger table router rtl
`ifndef RING_FINGER_TABLE_ROUTER_UNIT_ASSERT_SVH
`define RING_FINGER_TABLE_ROUTER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RFT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define RFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rft_pkg.sv
// shared types and constants of the ring finger table router
`default_nettype none
package rft_pkg;
  localparam int IdBits   = 16;
  localparam int Spares   = 4;
  localparam int EpBits   = 48;
  localparam int FqDepth  = 2;

  typedef enum logic [2:0] {
    ACT_LOOKUP = 3'd0, ACT_SET = 3'd1, ACT_FAIL = 3'd2, ACT_LOAD = 3'd3, ACT_LIST = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0, KIND_SUCC = 3'd1, KIND_FWD = 3'd2, KIND_LIST = 3'd3,
    KIND_DONE = 3'd4, KIND_OUT = 3'd5
  } kind_t;

  // one accepted request, as queued between front and back
  typedef struct packed {
    logic [2:0]        action;
    logic [IdBits-1:0] key_id;
    logic [4:0]        entry_index;
    logic [IdBits-1:0] node_id;
    logic [EpBits-1:0] node_endpoint;
    logic [EpBits-1:0] sender_endpoint;
    logic [7:0]        hops;
    logic [4:0]        purpose;
    logic              last_entry;
  } req_t;

  // one result
  typedef struct packed {
    logic [2:0]        result_kind;
    logic [EpBits-1:0] dest_endpoint;
    logic [IdBits-1:0] found_id;
    logic [EpBits-1:0] found_endpoint;
    logic [IdBits-1:0] fwd_key;
    logic [EpBits-1:0] origin_endpoint;
    logic [7:0]        hop_count;
    logic [4:0]        purpose_out;
    logic [3:0]        list_position;
    logic              last_result;
  } res_t;

  // (lo, hi) open interval on the ring
  function automatic logic in_open(logic [IdBits-1:0] v, logic [IdBits-1:0] lo,
                                   logic [IdBits-1:0] hi);
    if (lo < hi) return (v > lo) && (v < hi);
    return (v > lo) || (v < hi);
  endfunction

  // (lo, hi] interval on the ring
  function automatic logic in_open_closed(logic [IdBits-1:0] v, logic [IdBits-1:0] lo,
                                          logic [IdBits-1:0] hi);
    if (lo < hi) return (v > lo) && (v <= hi);
    return (v > lo) || (v <= hi);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/rft_front.sv
// input stage and request queue of the router
`default_nettype none
module rft_front import rft_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  req_t        in_req,
  output logic        q_valid,
  input  wire         q_ready,
  output req_t        q_req
);
  `include "ring_finger_table_router_unit_assert.svh"

  req_t mem [FqDepth];
  logic wp, rp;
  logic [1:0] count;

  assign in_ready = (count != 2'(FqDepth));
  assign q_valid  = (count != 2'd0);
  assign q_req    = mem[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_req;
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

  `RFT_ASSERT_IMP(a_fill_bound, 1'b1, count <= 2'(FqDepth), "queue overfilled")
  `RFT_ASSERT_NEXT(a_empty_push, (count == 2'd0) && in_valid, q_valid, "push lost")
  `RFT_ASSERT_IMP(a_full_stall, count == 2'(FqDepth), !in_ready, "full queue took a beat")
endmodule
`default_nettype wire

FILE: rtl/rft_back.sv
// table state and request execution of the router
`default_nettype none
module rft_back import rft_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire  [IdBits-1:0] self_id,
  input  wire  [EpBits-1:0] self_ep,
  input  wire               q_valid,
  output logic              q_ready,
  input  req_t              q_req,
  output logic              out_valid,
  input  wire               out_ready,
  output res_t              out_res
);
  `include "ring_finger_table_router_unit_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_EXEC = 3'b010, ST_LIST = 3'b100
  } state_t;

  state_t state;
  req_t cur;
  logic [2:0] pos;
  logic [IdBits-1:0] f_id [1:IdBits];
  logic [EpBits-1:0] f_ep [1:IdBits];
  logic [IdBits-1:0] s_id [1:Spares];
  logic [EpBits-1:0] s_ep [1:Spares];
  logic [IdBits+EpBits-1:0] staged [1:Spares];
  logic sender_ok;

  // forward target: highest valid finger strictly inside (self, key)
  logic [EpBits-1:0] fwd_dest;
  always_comb begin
    fwd_dest = self_ep;
    for (int i = 1; i <= IdBits; i++) begin
      if ((f_ep[i] != '0) && in_open(f_id[i], self_id, cur.key_id)) fwd_dest = f_ep[i];
    end
  end

  // result for the current request
  res_t res;
  always_comb begin
    res = '0;
    res.last_result = 1'b1;
    res.result_kind = KIND_DONE;
    unique case (cur.action)
      ACT_LOOKUP: begin
        res.dest_endpoint = cur.sender_endpoint;
        if (f_ep[1] == '0) res.result_kind = KIND_OUT;
        else if (in_open_closed(cur.key_id, self_id, f_id[1])) begin
          res.found_id = f_id[1];
          res.found_endpoint = f_ep[1];
          if (cur.purpose == 5'd1) begin
            res.result_kind = KIND_INSERT;
            res.origin_endpoint = self_ep;
          end else begin
            res.result_kind = KIND_SUCC;
            res.hop_count = cur.hops;
            res.purpose_out = cur.purpose;
          end
        end else begin
          res.result_kind = KIND_FWD;
          res.dest_endpoint = fwd_dest;
          res.fwd_key = cur.key_id;
          res.origin_endpoint = cur.sender_endpoint;
          res.hop_count = (cur.hops == 8'hff) ? 8'hff : cur.hops + 8'd1;
          res.purpose_out = cur.purpose;
        end
      end
      ACT_FAIL: begin
        if ((cur.node_endpoint != '0) && (cur.node_endpoint == f_ep[1]) && (s_ep[1] == '0))
        begin
          res.result_kind = KIND_OUT;
          res.dest_endpoint = cur.sender_endpoint;
        end
      end
      ACT_LIST: begin
        res.result_kind = KIND_LIST;
        res.dest_endpoint = cur.sender_endpoint;
        res.found_id = (pos == 3'd1) ? f_id[1] : s_id[pos - 3'd1];
        res.found_endpoint = (pos == 3'd1) ? f_ep[1] : s_ep[pos - 3'd1];
        res.list_position = {1'b0, pos};
        res.last_result = (pos == 3'(Spares));
      end
      default: ;
    endcase
  end

  assign q_ready = (state == ST_IDLE);
  wire fire = out_valid && out_ready;
  wire slot_free = !out_valid || out_ready;
  wire issue = ((state == ST_EXEC) || (state == ST_LIST)) && slot_free;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_valid <= 1'b0;
    end else begin
      if (issue) out_valid <= 1'b1;
      else if (fire) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (q_valid) begin
          state <= (q_req.action == ACT_LIST) ? ST_LIST : ST_EXEC;
        end
        ST_EXEC: if (slot_free) begin
          state <= ST_IDLE;
        end
        ST_LIST: if (slot_free) begin
          if (pos == 3'(Spares)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request capture, list position and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur <= q_req; pos <= 3'd1;
    end
    if (issue) begin
      out_res <= res;
      pos <= pos + 3'd1;
    end
  end

  // table updates, done as the result is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      sender_ok <= 1'b1;
      for (int i = 1; i <= IdBits; i++) begin f_id[i] <= '0; f_ep[i] <= '0; end
      for (int i = 1; i <= Spares; i++) begin s_id[i] <= '0; s_ep[i] <= '0; end
    end else if (state == ST_EXEC && slot_free) begin
      case (cur.action)
        ACT_SET: if (cur.entry_index >= 5'd1 && cur.entry_index <= 5'(IdBits)) begin
          f_id[cur.entry_index] <= cur.node_id;
          f_ep[cur.entry_index] <= cur.node_endpoint;
        end
        ACT_FAIL: if (cur.node_endpoint != '0) begin
          for (int i = 2; i <= IdBits; i++)
            if (f_ep[i] == cur.node_endpoint) begin f_id[i] <= '0; f_ep[i] <= '0; end
          if (cur.node_endpoint == f_ep[1]) begin
            if (s_ep[1] != '0) begin
              f_id[1] <= s_id[1]; f_ep[1] <= s_ep[1];
              for (int i = 1; i < Spares; i++) begin
                s_id[i] <= s_id[i+1]; s_ep[i] <= s_ep[i+1];
              end
              s_id[Spares] <= '0; s_ep[Spares] <= '0;
            end else begin
              f_id[1] <= '0; f_ep[1] <= '0;
            end
          end
        end
        ACT_LOAD: begin
          if (cur.last_entry) begin
            if (sender_ok && (cur.sender_endpoint == f_ep[1])) begin
              for (int i = 1; i <= Spares; i++) begin
                if (cur.entry_index == 5'(i)) begin
                  s_id[i] <= cur.node_id; s_ep[i] <= cur.node_endpoint;
                end else begin
                  s_id[i] <= staged[i][IdBits+EpBits-1:EpBits];
                  s_ep[i] <= staged[i][EpBits-1:0];
                end
              end
            end
            sender_ok <= 1'b1;
          end else if (cur.sender_endpoint != f_ep[1]) sender_ok <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // staging entries, no reset
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && slot_free && cur.action == ACT_LOAD)
      for (int i = 1; i <= Spares; i++)
        if (cur.entry_index == 5'(i)) staged[i] <= {cur.node_id, cur.node_endpoint};
  end

  `RFT_ASSERT_IMP(a_onehot_state, 1'b1, $onehot(state), "state not one-hot")
  `RFT_ASSERT_IMP(a_take_idle, q_valid && q_ready, state == ST_IDLE, "took request while busy")
  `RFT_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(out_res),
                   "result dropped under stall")
endmodule
`default_nettype wire

FILE: rtl/ring_finger_table_router_unit.sv
// ring finger table router top level: config registers, front queue, back engine
// path: a request beat passes the front queue and the back capture before its result beat is registered out
// the back engine takes a new request only while idle, so it handles one request at a time; a list
// read gives 4 beats, issued by the back sequencer as the output frees; the 2-deep queue absorbs bursts
// reset: synchronous active-high rst clears fingers, spares, queue and config
`default_nettype none
module ring_finger_table_router_unit import rft_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [151:0] s_tdata,  // action, key_id, entry_index, node_id, node_endpoint,
                                 // sender_endpoint, hops, purpose (bit 149 up: zero)
  input  wire          s_tlast,  // last_entry
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [199:0] m_tdata,  // result_kind, dest_endpoint, found_id, found_endpoint,
                                 // fwd_key, origin_endpoint, hop_count, purpose_out,
                                 // list_position (bit 196 up: zero)
  output logic         m_tlast,  // last_result
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  localparam logic [3:0] AddrSelfId = 4'h0;
  localparam logic [3:0] AddrSelfEp = 4'h8;

  logic [IdBits-1:0] self_id;
  logic [EpBits-1:0] self_ep;
  req_t in_req, q_req;
  res_t res;
  logic q_valid, q_ready;

  assign pready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id <= '0; self_ep <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrSelfId) self_id <= pwdata[IdBits-1:0];
      if (paddr == AddrSelfEp) self_ep <= pwdata[EpBits-1:0];
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr == AddrSelfId) prdata = {48'd0, self_id};
    else if (paddr == AddrSelfEp) prdata = {16'd0, self_ep};
  end

  // input beat unpacking
  assign in_req.action          = s_tdata[2:0];
  assign in_req.key_id          = s_tdata[18:3];
  assign in_req.entry_index     = s_tdata[23:19];
  assign in_req.node_id         = s_tdata[39:24];
  assign in_req.node_endpoint   = s_tdata[87:40];
  assign in_req.sender_endpoint = s_tdata[135:88];
  assign in_req.hops            = s_tdata[143:136];
  assign in_req.purpose         = s_tdata[148:144];
  assign in_req.last_entry      = s_tlast;

  rft_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  rft_back u_back (
    .clk(clk), .rst(rst), .self_id(self_id), .self_ep(self_ep),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  // output beat packing
  assign m_tdata = {4'd0, res.list_position, res.purpose_out, res.hop_count,
                    res.origin_endpoint, res.fwd_key, res.found_endpoint, res.found_id,
                    res.dest_endpoint, res.result_kind};
  assign m_tlast = res.last_result;
endmodule
`default_nettype wire
